// File: design/qat_pkg.sv
// qat_pkg: shared types, constants and the sine/cosine table builder for the
// quad affine transform block. Used by every module but qat_fifo; depends on nothing.
package qat_pkg;

  // Command codes
  localparam logic [1:0] CMD_LOAD      = 2'd0;
  localparam logic [1:0] CMD_TRANSLATE = 2'd1;
  localparam logic [1:0] CMD_SCALE     = 2'd2;
  localparam logic [1:0] CMD_ROTATE    = 2'd3;

  // Field widths fixed by the interface
  localparam int CMD_W   = 2;
  localparam int SLOT_W  = 2;
  localparam int VAL_W   = 16;
  localparam int ANGLE_W = 10;
  localparam int K_W     = 16;   // Q4.12 factor or Q1.14 sine/cosine
  localparam int OUT_W   = 16;
  localparam int VNUM_W  = 2;

  // Fraction bits of the two multiplier formats
  localparam int SCALE_FRAC = 12;
  localparam int TRIG_FRAC  = 14;

  // Angle handling
  localparam int DEG_PER_HALF_TURN = 180;
  localparam int TRIG_STEPS        = 90;   // table entries for 0..89 degrees

  // Defaults for the top-level parameters
  localparam int VERTEX_COUNT_DEF = 4;
  localparam int COORD_WIDTH_DEF  = 16;

  // Queue depths
  localparam int CMDQ_DEPTH = 2;
  localparam int OUTQ_DEPTH = 4;

  typedef logic signed [K_W-1:0] trig_t;
  typedef trig_t trig_tab_t [TRIG_STEPS];

  // One decoded command as it travels from the front to the back
  typedef struct packed {
    logic [CMD_W-1:0]         cmd;
    logic [SLOT_W-1:0]        slot;
    logic signed [VAL_W-1:0]  xv;
    logic signed [VAL_W-1:0]  yv;
    logic signed [K_W-1:0]    k0;   // x weight of new x
    logic signed [K_W-1:0]    k1;   // y weight of new x
    logic signed [K_W-1:0]    k2;   // x weight of new y
    logic signed [K_W-1:0]    k3;   // y weight of new y
  } cmd_entry_t;

  // One reported vertex
  typedef struct packed {
    logic [VNUM_W-1:0]        vnum;
    logic signed [OUT_W-1:0]  x;
    logic signed [OUT_W-1:0]  y;
    logic                     last;
  } res_t;

  // Unsigned 64-bit quotient by shift and subtract; table building only
  function automatic longint unsigned div_u64(input longint unsigned num,
                                              input longint unsigned den);
    longint unsigned quo;
    longint unsigned part;
    quo  = '0;
    part = '0;
    for (int i = 63; i >= 0; i--) begin
      part = {part[62:0], num[i]};
      quo  = quo << 1;
      if (part >= den) begin
        part   = part - den;
        quo[0] = 1'b1;
      end
    end
    return quo;
  endfunction

  // Q1.14 sine or cosine of r degrees (0 <= r < 90) by a Q30 Taylor series,
  // rounded to nearest. Evaluated at elaboration only.
  function automatic trig_t trig_q14(input int unsigned r, input bit want_sin);
    longint unsigned pi_q30;
    longint unsigned one_q30;
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint unsigned d;
    longint unsigned k;
    longint acc;
    pi_q30  = 64'd3373259426;
    one_q30 = 64'd1073741824;
    x    = div_u64(64'(r) * pi_q30, 64'(DEG_PER_HALF_TURN));
    x2   = (x * x) >> 30;
    term = want_sin ? x : one_q30;
    acc  = longint'(term);
    for (k = 1; k <= 12; k++) begin
      d = want_sin ? (2 * k) * (2 * k + 1) : (2 * k - 1) * (2 * k);
      term = div_u64((term * x2) >> 30, d);
      if (k[0]) acc = acc - longint'(term);
      else      acc = acc + longint'(term);
    end
    if (acc < 0) acc = 0;
    return trig_t'(((64'(acc) * 64'd16384) + (64'd1 << 29)) >> 30);
  endfunction

  function automatic trig_tab_t build_trig_tab(input bit want_sin);
    trig_tab_t tab;
    for (int unsigned i = 0; i < TRIG_STEPS; i++) begin
      tab[i] = trig_q14(i, want_sin);
    end
    return tab;
  endfunction

endpackage

// File: design/qat_fifo.sv
// qat_fifo: small first-in first-out queue of packed beats with fill count.
// Used for the command queue and the result queue; depends on nothing.
module qat_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  input  logic [WIDTH-1:0]           din,
  input  logic                       pop,
  output logic [WIDTH-1:0]           dout,
  output logic                       full,
  output logic                       empty,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem[rd_ptr];

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      if (do_pop)  rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      if (do_push && !do_pop)      count <= count + CW'(1);
      else if (!do_push && do_pop) count <= count - CW'(1);
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr] <= din;
  end

endmodule

// File: design/qat_front.sv
// qat_front: decodes one input beat into a command entry: reduces the angle
// to one turn, looks up sine and cosine, and picks the four weights. Uses qat_pkg.
module qat_front (
  input  logic [qat_pkg::CMD_W-1:0]           cmd,
  input  logic [qat_pkg::SLOT_W-1:0]          vertex_slot,
  input  logic signed [qat_pkg::VAL_W-1:0]    x_value,
  input  logic signed [qat_pkg::VAL_W-1:0]    y_value,
  input  logic signed [qat_pkg::K_W-1:0]      scale_value,
  input  logic signed [qat_pkg::ANGLE_W-1:0]  angle_degrees,
  output qat_pkg::cmd_entry_t                 entry
);

  localparam qat_pkg::trig_tab_t SIN_TAB = qat_pkg::build_trig_tab(1'b1);
  localparam qat_pkg::trig_tab_t COS_TAB = qat_pkg::build_trig_tab(1'b0);

  logic [10:0]         shifted;
  logic [8:0]          ang;
  logic [1:0]          quad;
  logic [6:0]          rem;
  qat_pkg::trig_t      s0;
  qat_pkg::trig_t      c0;
  qat_pkg::trig_t      s;
  qat_pkg::trig_t      c;

  // Angle modulo 360: offset by two turns, then take off whole turns
  always_comb begin
    shifted = 11'($signed({angle_degrees[qat_pkg::ANGLE_W-1], angle_degrees}) + 11'sd720);
    priority if (shifted >= 11'd1080) ang = 9'(shifted - 11'd1080);
    else if (shifted >= 11'd720)      ang = 9'(shifted - 11'd720);
    else if (shifted >= 11'd360)      ang = 9'(shifted - 11'd360);
    else                              ang = 9'(shifted);
  end

  // Quadrant and angle within it
  always_comb begin
    priority if (ang >= 9'd270) begin
      quad = 2'd3;
      rem  = 7'(ang - 9'd270);
    end else if (ang >= 9'd180) begin
      quad = 2'd2;
      rem  = 7'(ang - 9'd180);
    end else if (ang >= 9'd90) begin
      quad = 2'd1;
      rem  = 7'(ang - 9'd90);
    end else begin
      quad = 2'd0;
      rem  = 7'(ang);
    end
  end

  assign s0 = SIN_TAB[rem];
  assign c0 = COS_TAB[rem];

  // Quadrant symmetry
  always_comb begin
    unique case (quad)
      2'd0: begin
        s = s0;
        c = c0;
      end
      2'd1: begin
        s = c0;
        c = -s0;
      end
      2'd2: begin
        s = -s0;
        c = -c0;
      end
      default: begin
        s = -c0;
        c = s0;
      end
    endcase
  end

  // Weights: new x = x*k0 + y*k1, new y = x*k2 + y*k3
  always_comb begin
    entry.cmd  = cmd;
    entry.slot = vertex_slot;
    entry.xv   = x_value;
    entry.yv   = y_value;
    unique case (cmd)
      qat_pkg::CMD_SCALE: begin
        entry.k0 = scale_value;
        entry.k1 = '0;
        entry.k2 = '0;
        entry.k3 = scale_value;
      end
      qat_pkg::CMD_ROTATE: begin
        entry.k0 = c;
        entry.k1 = -s;
        entry.k2 = s;
        entry.k3 = c;
      end
      default: begin
        entry.k0 = '0;
        entry.k1 = '0;
        entry.k2 = '0;
        entry.k3 = '0;
      end
    endcase
  end

endmodule

// File: design/qat_back.sv
// qat_back: holds the vertex store and runs each command over all vertices,
// one vertex per cycle while the result queue has room, through four shared
// multipliers and a rounding/saturation stage. Uses qat_pkg.
module qat_back #(
  parameter int VERTEX_COUNT = qat_pkg::VERTEX_COUNT_DEF,
  parameter int COORD_WIDTH  = qat_pkg::COORD_WIDTH_DEF,
  parameter int OUT_DEPTH    = qat_pkg::OUTQ_DEPTH
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cmd_valid,
  input  qat_pkg::cmd_entry_t            cmd_entry,
  output logic                           cmd_pop,
  input  logic [$clog2(OUT_DEPTH+1)-1:0] out_count,
  output logic                           out_push,
  output qat_pkg::res_t                  out_beat
);

  localparam int IW   = $clog2(VERTEX_COUNT);
  localparam int PW   = COORD_WIDTH + qat_pkg::K_W;
  localparam int SW   = PW + 1;
  localparam int CNTW = $clog2(OUT_DEPTH + 1) + 1;

  localparam logic [1:0] SH_NONE = 2'd0;
  localparam logic [1:0] SH_Q12  = 2'd1;
  localparam logic [1:0] SH_Q14  = 2'd2;

  localparam logic signed [SW-1:0] SAT_HI = {{(SW-COORD_WIDTH+1){1'b0}},
                                             {(COORD_WIDTH-1){1'b1}}};
  localparam logic signed [SW-1:0] SAT_LO = {{(SW-COORD_WIDTH+1){1'b1}},
                                             {(COORD_WIDTH-1){1'b0}}};

  logic signed [COORD_WIDTH-1:0] vx [VERTEX_COUNT];
  logic signed [COORD_WIDTH-1:0] vy [VERTEX_COUNT];

  logic [IW-1:0]                 idx;
  logic                          issue;
  logic                          last_issue;
  logic                          load_hit;
  logic signed [COORD_WIDTH-1:0] cur_x;
  logic signed [COORD_WIDTH-1:0] cur_y;
  logic signed [PW-1:0]          m0, m1, m2, m3;
  logic signed [PW-1:0]          p0x_next, p1x_next, p0y_next, p1y_next;
  logic [1:0]                    shift_next;

  logic                          s1_valid;
  logic [IW-1:0]                 s1_idx;
  logic                          s1_last;
  logic [1:0]                    s1_shift;
  logic signed [PW-1:0]          p0x, p1x, p0y, p1y;

  logic signed [COORD_WIDTH-1:0] new_x;
  logic signed [COORD_WIDTH-1:0] new_y;

  // Divide by a power of two toward zero, then saturate to the store width
  function automatic logic signed [COORD_WIDTH-1:0] trunc_sat(
    input logic signed [SW-1:0] v,
    input logic [1:0]           sh
  );
    logic signed [SW-1:0] q;
    logic signed [SW-1:0] bias;
    unique case (sh)
      SH_Q12: begin
        bias = v[SW-1] ? (SW'(1) <<< qat_pkg::SCALE_FRAC) - SW'(1) : '0;
        q    = (v + bias) >>> qat_pkg::SCALE_FRAC;
      end
      SH_Q14: begin
        bias = v[SW-1] ? (SW'(1) <<< qat_pkg::TRIG_FRAC) - SW'(1) : '0;
        q    = (v + bias) >>> qat_pkg::TRIG_FRAC;
      end
      default: begin
        bias = '0;
        q    = v;
      end
    endcase
    if (q > SAT_HI)      return COORD_WIDTH'(SAT_HI);
    else if (q < SAT_LO) return COORD_WIDTH'(SAT_LO);
    else                 return COORD_WIDTH'(q);
  endfunction

  // Issue one vertex when a command waits and the result queue has room
  assign issue = cmd_valid &&
                 ((CNTW'(out_count) + CNTW'(s1_valid)) < CNTW'(OUT_DEPTH));
  assign last_issue = (idx == IW'(VERTEX_COUNT - 1));
  assign cmd_pop    = issue && last_issue;

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (issue) begin
      idx <= last_issue ? '0 : idx + IW'(1);
    end
  end

  // Stage 1: read vertex, form the four products
  assign cur_x    = vx[idx];
  assign cur_y    = vy[idx];
  assign load_hit = (IW'(cmd_entry.slot) == idx) && (VERTEX_COUNT > (1 << qat_pkg::SLOT_W) ||
                    {1'b0, cmd_entry.slot} < (qat_pkg::SLOT_W+1)'(VERTEX_COUNT));
  assign m0 = PW'(cur_x) * PW'(cmd_entry.k0);
  assign m1 = PW'(cur_y) * PW'(cmd_entry.k1);
  assign m2 = PW'(cur_x) * PW'(cmd_entry.k2);
  assign m3 = PW'(cur_y) * PW'(cmd_entry.k3);

  always_comb begin
    unique case (cmd_entry.cmd)
      qat_pkg::CMD_LOAD: begin
        p0x_next   = load_hit ? PW'(cmd_entry.xv) : PW'(cur_x);
        p1x_next   = '0;
        p0y_next   = load_hit ? PW'(cmd_entry.yv) : PW'(cur_y);
        p1y_next   = '0;
        shift_next = SH_NONE;
      end
      qat_pkg::CMD_TRANSLATE: begin
        p0x_next   = PW'(cur_x);
        p1x_next   = PW'(cmd_entry.xv);
        p0y_next   = PW'(cur_y);
        p1y_next   = PW'(cmd_entry.yv);
        shift_next = SH_NONE;
      end
      qat_pkg::CMD_SCALE: begin
        p0x_next   = m0;
        p1x_next   = m1;
        p0y_next   = m2;
        p1y_next   = m3;
        shift_next = SH_Q12;
      end
      default: begin
        p0x_next   = m0;
        p1x_next   = m1;
        p0y_next   = m2;
        p1y_next   = m3;
        shift_next = SH_Q14;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      s1_idx   <= idx;
      s1_last  <= last_issue;
      s1_shift <= shift_next;
      p0x      <= p0x_next;
      p1x      <= p1x_next;
      p0y      <= p0y_next;
      p1y      <= p1y_next;
    end
  end

  // Stage 2: sum, scale down, saturate, write back and report
  assign new_x = trunc_sat(SW'(p0x) + SW'(p1x), s1_shift);
  assign new_y = trunc_sat(SW'(p0y) + SW'(p1y), s1_shift);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < VERTEX_COUNT; i++) begin
        vx[i] <= '0;
        vy[i] <= '0;
      end
    end else if (s1_valid) begin
      vx[s1_idx] <= new_x;
      vy[s1_idx] <= new_y;
    end
  end

  assign out_push      = s1_valid;
  assign out_beat.vnum = qat_pkg::VNUM_W'(s1_idx);
  assign out_beat.x    = qat_pkg::OUT_W'(new_x);
  assign out_beat.y    = qat_pkg::OUT_W'(new_y);
  assign out_beat.last = s1_last;

endmodule

// File: design/quad_affine_transform_top.sv
// quad_affine_transform_top: top level of the 2-D translate/scale/rotate engine.
// Instantiates qat_front, qat_fifo (command and result queues) and qat_back; uses qat_pkg.
//
// Usage:
//   Command channel: drive cmd and its fields with push high; a beat is taken
//   at a clock edge where push is high and full is low. Commands: load vertex,
//   translate, scale (Q4.12), rotate (whole degrees, counterclockwise).
//   Result channel: while empty is low the oldest vertex report is on
//   vertex_number/out_x/out_y/last_vertex; pop high with empty low takes it.
//   Every command yields VERTEX_COUNT reports in vertex order, the final one
//   with last_vertex set.
// Timing:
//   The back end works one vertex per cycle through four shared multipliers
//   while the result queue has room. The first report passes the command
//   queue, the stage 1 registers and the result queue before it is visible;
//   a two-entry command queue keeps the front taking beats.
// Reset: rst (synchronous, active high) clears all vertices to zero and
//   empties both queues.
// Stall: when the receiver stops popping, the four-entry result queue fills,
//   the back end holds, then the command queue fills and full rises.
module quad_affine_transform_top #(
  parameter int VERTEX_COUNT = qat_pkg::VERTEX_COUNT_DEF,
  parameter int COORD_WIDTH  = qat_pkg::COORD_WIDTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               push,
  output logic                               full,
  input  logic [qat_pkg::CMD_W-1:0]          cmd,
  input  logic [qat_pkg::SLOT_W-1:0]         vertex_slot,
  input  logic signed [qat_pkg::VAL_W-1:0]   x_value,
  input  logic signed [qat_pkg::VAL_W-1:0]   y_value,
  input  logic signed [qat_pkg::K_W-1:0]     scale_value,
  input  logic signed [qat_pkg::ANGLE_W-1:0] angle_degrees,
  output logic                               empty,
  input  logic                               pop,
  output logic [qat_pkg::VNUM_W-1:0]         vertex_number,
  output logic signed [qat_pkg::OUT_W-1:0]   out_x,
  output logic signed [qat_pkg::OUT_W-1:0]   out_y,
  output logic                               last_vertex
);

  localparam int CMD_BITS = $bits(qat_pkg::cmd_entry_t);
  localparam int RES_BITS = $bits(qat_pkg::res_t);
  localparam logic [qat_pkg::VNUM_W-1:0] LAST_NUM = qat_pkg::VNUM_W'(VERTEX_COUNT - 1);

  qat_pkg::cmd_entry_t front_entry;
  qat_pkg::cmd_entry_t head_entry;
  logic [CMD_BITS-1:0] head_bits;
  logic                cmdq_empty;
  logic [$clog2(qat_pkg::CMDQ_DEPTH+1)-1:0] cmdq_count;
  logic                cmd_pop;

  qat_pkg::res_t       res_in;
  qat_pkg::res_t       res_out;
  logic [RES_BITS-1:0] res_bits;
  logic                out_push;
  logic                outq_full;
  logic [$clog2(qat_pkg::OUTQ_DEPTH+1)-1:0] outq_count;

  // Front: decode the command beat
  qat_front u_front (
    .cmd           (cmd),
    .vertex_slot   (vertex_slot),
    .x_value       (x_value),
    .y_value       (y_value),
    .scale_value   (scale_value),
    .angle_degrees (angle_degrees),
    .entry         (front_entry)
  );

  // Command queue between front and back
  qat_fifo #(
    .WIDTH (CMD_BITS),
    .DEPTH (qat_pkg::CMDQ_DEPTH)
  ) u_cmdq (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .din   (front_entry),
    .pop   (cmd_pop),
    .dout  (head_bits),
    .full  (full),
    .empty (cmdq_empty),
    .count (cmdq_count)
  );

  assign head_entry = qat_pkg::cmd_entry_t'(head_bits);

  // Back: per-vertex execution
  qat_back #(
    .VERTEX_COUNT (VERTEX_COUNT),
    .COORD_WIDTH  (COORD_WIDTH),
    .OUT_DEPTH    (qat_pkg::OUTQ_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (!cmdq_empty),
    .cmd_entry (head_entry),
    .cmd_pop   (cmd_pop),
    .out_count (outq_count),
    .out_push  (out_push),
    .out_beat  (res_in)
  );

  // Result queue
  qat_fifo #(
    .WIDTH (RES_BITS),
    .DEPTH (qat_pkg::OUTQ_DEPTH)
  ) u_outq (
    .clk   (clk),
    .rst   (rst),
    .push  (out_push),
    .din   (res_in),
    .pop   (pop),
    .dout  (res_bits),
    .full  (outq_full),
    .empty (empty),
    .count (outq_count)
  );

  assign res_out       = qat_pkg::res_t'(res_bits);
  assign vertex_number = res_out.vnum;
  assign out_x         = res_out.x;
  assign out_y         = res_out.y;
  assign last_vertex   = res_out.last;

  // Result queue never receives a beat it has no room for
  a_outq_room: assert property (@(posedge clk) disable iff (rst)
    out_push |-> !outq_full)
    else $error("result queue overflow");

  // Back end only retires a command that is present
  a_cmd_present: assert property (@(posedge clk) disable iff (rst)
    cmd_pop |-> (cmdq_count != '0))
    else $error("command retired from empty queue");

  // The final report of a run is the highest vertex
  a_last_index: assert property (@(posedge clk) disable iff (rst)
    (!empty && last_vertex) |-> (vertex_number == LAST_NUM))
    else $error("last_vertex on wrong vertex");

  // Reset leaves no reports waiting
  a_reset_empty: assert property (@(posedge clk)
    rst |=> empty)
    else $error("results pending after reset");

endmodule

// File: tb/quad_affine_transform_top_test.sv
// quad_affine_transform_top_test: self-checking bench for the quad affine transform engine.
// Predicts every vertex report with its own integer model; needs qat_pkg and the top level.
`timescale 1ns / 1ps

module quad_affine_transform_top_test;

  localparam int NUM_VERTS    = 4;
  localparam int FULL_TURN    = 360;
  localparam int QUARTER_TURN = 90;
  localparam int RANDOM_CMDS  = 400;
  localparam int MAX_PRINTS   = 50;

  // One command beat as offered on the input side
  typedef struct packed {
    logic [qat_pkg::CMD_W-1:0]          op;
    logic [qat_pkg::SLOT_W-1:0]         slot;
    logic signed [qat_pkg::VAL_W-1:0]   xv;
    logic signed [qat_pkg::VAL_W-1:0]   yv;
    logic signed [qat_pkg::K_W-1:0]     factor;
    logic signed [qat_pkg::ANGLE_W-1:0] angle;
  } cmd_beat_t;

  localparam int BEAT_BITS = $bits(cmd_beat_t);

  // Polygon predictor and queue of vertex reports still owed by the block
  class vertex_scoreboard;
    logic signed [qat_pkg::OUT_W-1:0] poly_x [NUM_VERTS];
    logic signed [qat_pkg::OUT_W-1:0] poly_y [NUM_VERTS];
    longint                           sin_q14 [QUARTER_TURN];
    longint                           cos_q14 [QUARTER_TURN];
    qat_pkg::res_t                    reports_due [$];
    int unsigned                      error_count;
    int unsigned                      commands_taken;

    function new();
      for (int d = 0; d < QUARTER_TURN; d++) begin
        sin_q14[d] = quarter_wave(unsigned'(d), 1'b1);
        cos_q14[d] = quarter_wave(unsigned'(d), 1'b0);
      end
      for (int i = 0; i < NUM_VERTS; i++) begin
        poly_x[i] = '0;
        poly_y[i] = '0;
      end
      error_count = 0;
      commands_taken = 0;
    endfunction

    // Q1.14 sine/cosine of 0..89 degrees: Q30 power series, rounded to nearest
    function longint quarter_wave(int unsigned deg, bit sine);
      longint unsigned half_turn_q30;
      longint unsigned rad;
      longint unsigned rad_sq;
      longint unsigned term;
      longint unsigned div;
      longint          sum;
      half_turn_q30 = 64'd3373259426;
      rad    = (64'(deg) * half_turn_q30) / 64'd180;
      rad_sq = (rad * rad) >> 30;
      term   = sine ? rad : (64'd1 << 30);
      sum    = longint'(term);
      for (longint unsigned n = 1; n <= 12; n++) begin
        div  = sine ? (2 * n) * (2 * n + 1) : (2 * n - 1) * (2 * n);
        term = ((term * rad_sq) >> 30) / div;
        if (n[0]) sum -= longint'(term);
        else      sum += longint'(term);
      end
      if (sum < 0) sum = 0;
      return longint'(((64'(sum) * 64'd16384) + (64'd1 << 29)) >> 30);
    endfunction

    function logic signed [qat_pkg::OUT_W-1:0] clamp(longint v);
      if (v > 32767)  return 16'sh7fff;
      if (v < -32768) return 16'sh8000;
      return v[qat_pkg::OUT_W-1:0];
    endfunction

    // Apply one accepted command and queue the four reports it produces
    function void note_command(cmd_beat_t b);
      longint        x, y, nx, ny, s, c, f;
      int            a;
      qat_pkg::res_t r;
      commands_taken++;
      s = 0;
      c = 0;
      if (b.op == qat_pkg::CMD_ROTATE) begin
        a = int'(b.angle) % FULL_TURN;
        if (a < 0) a += FULL_TURN;
        case (a / QUARTER_TURN)
          0: begin s = sin_q14[a % QUARTER_TURN];  c = cos_q14[a % QUARTER_TURN];  end
          1: begin s = cos_q14[a % QUARTER_TURN];  c = -sin_q14[a % QUARTER_TURN]; end
          2: begin s = -sin_q14[a % QUARTER_TURN]; c = -cos_q14[a % QUARTER_TURN]; end
          default: begin
            s = -cos_q14[a % QUARTER_TURN];
            c = sin_q14[a % QUARTER_TURN];
          end
        endcase
      end
      if (b.op == qat_pkg::CMD_LOAD) begin
        if (b.slot < NUM_VERTS) begin
          poly_x[b.slot] = b.xv;
          poly_y[b.slot] = b.yv;
        end
      end else begin
        f = longint'(b.factor);
        for (int i = 0; i < NUM_VERTS; i++) begin
          x = longint'(poly_x[i]);
          y = longint'(poly_y[i]);
          case (b.op)
            qat_pkg::CMD_TRANSLATE: begin
              nx = x + longint'(b.xv);
              ny = y + longint'(b.yv);
            end
            qat_pkg::CMD_SCALE: begin
              nx = (x * f) / 4096;
              ny = (y * f) / 4096;
            end
            default: begin
              nx = (x * c - y * s) / 16384;
              ny = (x * s + y * c) / 16384;
            end
          endcase
          poly_x[i] = clamp(nx);
          poly_y[i] = clamp(ny);
        end
      end
      for (int i = 0; i < NUM_VERTS; i++) begin
        r.vnum = i[qat_pkg::VNUM_W-1:0];
        r.x    = poly_x[i];
        r.y    = poly_y[i];
        r.last = (i == NUM_VERTS - 1);
        reports_due.push_back(r);
      end
    endfunction

    task report(string what, longint got, longint want);
      error_count++;
      if (error_count <= MAX_PRINTS)
        $display("%0t MISMATCH %s: got %0d expected %0d", $realtime, what, got, want);
    endtask

    // Compare one popped vertex beat against the oldest report due
    task check_vertex(logic [qat_pkg::VNUM_W-1:0] vnum, logic signed [qat_pkg::OUT_W-1:0] x,
                      logic signed [qat_pkg::OUT_W-1:0] y, logic last);
      qat_pkg::res_t e;
      if (reports_due.size() == 0) begin
        report("vertex beat with none due, vertex_number", longint'(vnum), 0);
        return;
      end
      e = reports_due.pop_front();
      if (vnum !== e.vnum) report("vertex_number", longint'(vnum), longint'(e.vnum));
      if (x !== e.x)       report("out_x", longint'(x), longint'(e.x));
      if (y !== e.y)       report("out_y", longint'(y), longint'(e.y));
      if (last !== e.last) report("last_vertex", longint'(last), longint'(e.last));
    endtask
  endclass

  logic                               clk = 1'b0;
  logic                               rst = 1'b1;
  logic                               push = 1'b0;
  logic                               pop = 1'b0;
  logic [qat_pkg::CMD_W-1:0]          cmd = qat_pkg::CMD_LOAD;
  logic [qat_pkg::SLOT_W-1:0]         vertex_slot = '0;
  logic signed [qat_pkg::VAL_W-1:0]   x_value = '0;
  logic signed [qat_pkg::VAL_W-1:0]   y_value = '0;
  logic signed [qat_pkg::K_W-1:0]     scale_value = '0;
  logic signed [qat_pkg::ANGLE_W-1:0] angle_degrees = '0;
  logic                               full;
  logic                               empty;
  logic [qat_pkg::VNUM_W-1:0]         vertex_number;
  logic signed [qat_pkg::OUT_W-1:0]   out_x;
  logic signed [qat_pkg::OUT_W-1:0]   out_y;
  logic                               last_vertex;

  logic                               hold_pop = 1'b0;
  int unsigned                        cycle_no = 0;
  cmd_beat_t                          plan [$];
  vertex_scoreboard                   sb = new();

  quad_affine_transform_top dut (
    .clk(clk), .rst(rst), .push(push), .full(full), .cmd(cmd),
    .vertex_slot(vertex_slot), .x_value(x_value), .y_value(y_value),
    .scale_value(scale_value), .angle_degrees(angle_degrees),
    .empty(empty), .pop(pop), .vertex_number(vertex_number),
    .out_x(out_x), .out_y(out_y), .last_vertex(last_vertex)
  );

  always #6 clk = ~clk;

  always @(posedge clk) cycle_no <= cycle_no + 1;

  // Idle length: mostly none or short, now and then long
  function automatic int next_gap();
    int r;
    r = int'($urandom_range(0, 99));
    if (r < 55) return 0;
    if (r < 85) return int'($urandom_range(1, 3));
    if (r < 97) return int'($urandom_range(4, 12));
    return int'($urandom_range(20, 70));
  endfunction

  function automatic cmd_beat_t random_beat();
    cmd_beat_t b;
    b = BEAT_BITS'({$urandom, $urandom});
    return b;
  endfunction

  function automatic cmd_beat_t load_beat(int slot, int x, int y);
    cmd_beat_t b;
    b = random_beat();
    b.op = qat_pkg::CMD_LOAD;
    b.slot = qat_pkg::SLOT_W'(slot);
    b.xv = qat_pkg::VAL_W'(x);
    b.yv = qat_pkg::VAL_W'(y);
    return b;
  endfunction

  function automatic cmd_beat_t translate_beat(int x, int y);
    cmd_beat_t b;
    b = random_beat();
    b.op = qat_pkg::CMD_TRANSLATE;
    b.xv = qat_pkg::VAL_W'(x);
    b.yv = qat_pkg::VAL_W'(y);
    return b;
  endfunction

  function automatic cmd_beat_t scale_beat(int f);
    cmd_beat_t b;
    b = random_beat();
    b.op = qat_pkg::CMD_SCALE;
    b.factor = qat_pkg::K_W'(f);
    return b;
  endfunction

  function automatic cmd_beat_t rotate_beat(int a);
    cmd_beat_t b;
    b = random_beat();
    b.op = qat_pkg::CMD_ROTATE;
    b.angle = qat_pkg::ANGLE_W'(a);
    return b;
  endfunction

  // Coordinates and parameters that keep the polygon alive over several commands
  function automatic int pick_coord();
    if ($urandom_range(0, 9) == 0) return int'($signed(16'($urandom)));
    return int'($urandom_range(0, 8000)) - 4000;
  endfunction

  function automatic int pick_factor();
    int m;
    if ($urandom_range(0, 7) == 0) return int'($signed(16'($urandom)));
    m = int'($urandom_range(1024, 12000));
    return ($urandom_range(0, 4) == 0) ? -m : m;
  endfunction

  task automatic build_plan();
    int nload, nops;
    // Extremes, saturation and every command
    plan.push_back(load_beat(0, 32767, -32768));
    plan.push_back(load_beat(1, -32768, 32767));
    plan.push_back(load_beat(2, 0, 0));
    plan.push_back(load_beat(3, 1, -1));
    plan.push_back(translate_beat(1, 1));
    plan.push_back(translate_beat(-32768, -32768));
    plan.push_back(load_beat(0, 1000, 2000));
    plan.push_back(load_beat(1, -3000, 500));
    plan.push_back(load_beat(2, 32767, 32767));
    plan.push_back(load_beat(3, -32768, -7));
    plan.push_back(scale_beat(4096));
    plan.push_back(scale_beat(-1));
    plan.push_back(load_beat(0, 12345, -23456));
    plan.push_back(load_beat(3, -5, 3));
    plan.push_back(scale_beat(32767));
    plan.push_back(scale_beat(-32768));
    plan.push_back(load_beat(0, 1000, -2000));
    plan.push_back(load_beat(1, 30000, 30000));
    // Quadrant edges and angles beyond one turn
    plan.push_back(rotate_beat(90));
    plan.push_back(rotate_beat(-90));
    plan.push_back(rotate_beat(180));
    plan.push_back(rotate_beat(271));
    plan.push_back(rotate_beat(360));
    plan.push_back(rotate_beat(-360));
    plan.push_back(rotate_beat(511));
    plan.push_back(rotate_beat(-512));
    plan.push_back(scale_beat(0));
    // Random: mostly load-then-transform sequences, some pure noise
    for (int done = 0; done < RANDOM_CMDS; ) begin
      if ($urandom_range(0, 9) == 0) begin
        plan.push_back(random_beat());
        done++;
      end else begin
        nload = ($urandom_range(0, 9) < 8) ? NUM_VERTS : int'($urandom_range(1, 3));
        for (int k = 0; k < nload; k++) begin
          plan.push_back(load_beat((nload == NUM_VERTS) ? k : int'($urandom_range(0, 3)),
                                   pick_coord(), pick_coord()));
          done++;
        end
        nops = int'($urandom_range(1, 4));
        for (int k = 0; k < nops; k++) begin
          case ($urandom_range(1, 3))
            1: plan.push_back(($urandom_range(0, 7) == 0) ?
                              translate_beat(int'($signed(16'($urandom))),
                                             int'($signed(16'($urandom)))) :
                              translate_beat(int'($urandom_range(0, 1000)) - 500,
                                             int'($urandom_range(0, 1000)) - 500));
            2: plan.push_back(scale_beat(pick_factor()));
            default: plan.push_back(rotate_beat(int'($signed(10'($urandom)))));
          endcase
          done++;
        end
      end
    end
  endtask

  // Result side: pop with random idling, none in some stretches, none while held off
  initial begin
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (!rst && pop && !empty)
        sb.check_vertex(vertex_number, out_x, out_y, last_vertex);
      if (hold_pop || stall_left > 0) begin
        pop <= 1'b0;
        if (stall_left > 0) stall_left--;
      end else begin
        pop <= 1'b1;
        if ((cycle_no / 256) % 3 != 0 && $urandom_range(0, 3) == 0)
          stall_left = next_gap();
      end
    end
  end

  // Long hold-off on the result side so the block backs up to full
  initial begin
    while (sb.commands_taken < 120) @(posedge clk);
    hold_pop <= 1'b1;
    repeat (300) @(posedge clk);
    hold_pop <= 1'b0;
  end

  // Command side and end of run
  initial begin
    int gap;
    build_plan();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    foreach (plan[n]) begin
      gap = (n >= 150 && n < 230) ? 0 : next_gap();
      if (gap > 0) begin
        push <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      push          <= 1'b1;
      cmd           <= plan[n].op;
      vertex_slot   <= plan[n].slot;
      x_value       <= plan[n].xv;
      y_value       <= plan[n].yv;
      scale_value   <= plan[n].factor;
      angle_degrees <= plan[n].angle;
      @(posedge clk);
      while (full) @(posedge clk);
      sb.note_command(plan[n]);
    end
    push <= 1'b0;
    while (sb.reports_due.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (sb.error_count == 0) $display("quad_affine_transform_top_test: clean");
    else $display("quad_affine_transform_top_test: errors");
    $finish;
  end

  // Run limit
  initial begin
    #20_000_000;
    $display("quad_affine_transform_top_test: errors");
    $finish;
  end

endmodule

// File: quad_affine_transform_top.f
design/qat_pkg.sv
design/qat_fifo.sv
design/qat_front.sv
design/qat_back.sv
design/quad_affine_transform_top.sv
tb/quad_affine_transform_top_test.sv
